FILE: hw/rtl/j2g_pkg.sv
// Shared widths, constants and payload types of the J2 gravity acceleration block.
package j2g_pkg;

  localparam int POS_W  = 48;
  localparam int ACC_W  = 48;
  localparam int GM_W   = 49;
  localparam int RE_W   = 24;
  localparam int J2_W   = 32;
  localparam int CFG_W  = 49;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAV_PARAM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_RADIUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_J2_COEFF   = 2'd2;

  localparam logic [GM_W-1:0] GM_RESET = 49'd398600441800000;
  localparam logic [RE_W-1:0] RE_RESET = 24'd6378137;
  localparam logic [J2_W-1:0] J2_RESET = 32'd1190362000;

  // Bits of the multiplier operand consumed by one pipeline stage.
  localparam int DIGIT_W = 4;

  localparam int MAG_W   = 48;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int R2_W    = 96;
  localparam int Z5_W    = 97;
  localparam int ROOT_W  = 64;
  localparam int ROOT_SHIFT = 2 * ROOT_W - R2_W;
  localparam int KS_W    = 49;
  localparam int K_W     = 129;
  localparam int R2SQ_W  = 192;
  localparam int R2C_W   = 288;
  localparam int DEN_W   = 352;
  localparam int CR_W    = 206;
  localparam int C_SHIFT = 54;
  localparam int KR_W    = 225;
  localparam int P_W     = 226;
  localparam int M_W     = 261;
  localparam int G_W     = 310;
  localparam int NUM_W   = 358;
  localparam int QUO_W   = 48;
  localparam int MB_WIDE = 100;
  localparam int MB_MID  = 64;

  // 3 * 2^7 * 10^12 folds the J2 scale, the factor 1.5 and the mm to m conversion.
  localparam logic [KS_W-1:0] K_SCALE = 49'd384000000000000;
  // 10^6 * 2^48 is 15625 * 2^54.
  localparam logic [13:0] C_MANT = 14'd15625;
  localparam logic [R2_W-1:0] R2_LIMIT = 96'd1000000;

  localparam logic [QUO_W-1:0] POS_LIM = 48'h7FFF_FFFF_FFFF;
  localparam logic [QUO_W-1:0] NEG_LIM = 48'h8000_0000_0000;

  typedef struct packed {
    logic signed [POS_W-1:0] position_x;
    logic signed [POS_W-1:0] position_y;
    logic signed [POS_W-1:0] position_z;
  } position_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] accel_x;
    logic signed [ACC_W-1:0] accel_y;
    logic signed [ACC_W-1:0] accel_z;
    logic                    saturated;
  } accel_t;

endpackage

FILE: hw/rtl/j2_gravity_acceleration.sv
// J2 gravity acceleration: a request taken at one edge is delivered later with strobe.
// One request per cycle is taken; busy stays low, results come in request order.
// The pipeline runs through the multiplier chain (four operand bits per stage), the
// 64-stage square root and the 49-stage divider.
// Reset clears all valid bits and returns the configuration registers to their default values.
module j2_gravity_acceleration
  import j2g_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  position_t            position,
  output logic                 strobe,
  output accel_t               accel,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
  } a_side_t;

  typedef struct packed {
    logic [R2_W-1:0] r2;
    logic [Z5_W-1:0] z5;
    a_side_t         in;
  } sq_side_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [R2_W-1:0]   r2;
    a_side_t           in;
    logic              near;
  } c_side_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [KR_W-1:0]   kr;
    logic [P_W-1:0]    pz;
    a_side_t           in;
    logic              near;
  } d_side_t;

  typedef struct packed {
    a_side_t in;
    logic    bneg_xy;
    logic    bneg_z;
    logic    near;
  } f_side_t;

  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic [2:0]       neg;
    logic             bneg_xy;
    logic             bneg_z;
    logic             near;
  } g_side_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       bneg_xy;
    logic       bneg_z;
    logic       near;
  } h_side_t;

  typedef struct packed {
    logic [2*ROOT_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
  } root_t;

  function automatic logic [MAG_W-1:0] mag_of(input logic [POS_W-1:0] x);
    return x[POS_W-1] ? (~x + 1'b1) : x;
  endfunction

  // One bit of the square root: keep T - root^2 and try the next bit.
  function automatic root_t root_step(input root_t s, input int b);
    logic [2*ROOT_W:0] tr;
    root_t r;
    tr = ((2 * ROOT_W + 1)'(s.root) << (b + 1)) + ((2 * ROOT_W + 1)'(1) << (2 * b));
    r = s;
    if (tr <= (2 * ROOT_W + 1)'(s.rem)) begin
      r.rem  = s.rem - tr[2*ROOT_W-1:0];
      r.root = s.root | (ROOT_W'(1) << b);
    end
    return r;
  endfunction

  // Sign flip, then clip to the 48-bit range; the top bit is the clip flag.
  function automatic logic [ACC_W:0] clip(input logic [QUO_W-1:0] q, input logic over,
                                          input logic flip);
    logic [QUO_W-1:0] m;
    logic             s;
    m = q;
    s = 1'b0;
    if (flip) begin
      if (over || q > NEG_LIM) begin
        s = 1'b1;
        m = NEG_LIM;
      end
      return {s, ~m + 1'b1};
    end
    if (over || q > POS_LIM) begin
      s = 1'b1;
      m = POS_LIM;
    end
    return {s, m};
  endfunction

  // Configuration registers.
  logic [GM_W-1:0] grav_param;
  logic [RE_W-1:0] ref_radius;
  logic [J2_W-1:0] j2_coefficient;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      grav_param     <= GM_RESET;
      ref_radius     <= RE_RESET;
      j2_coefficient <= J2_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GRAV_PARAM: grav_param     <= cfg_data[GM_W-1:0];
        CFG_REF_RADIUS: ref_radius     <= cfg_data[RE_W-1:0];
        CFG_J2_COEFF:   j2_coefficient <= cfg_data[J2_W-1:0];
        default: ;
      endcase
    end
  end

  // The J2 factor K depends on the registers alone. This chain runs freely and
  // settles long before a request that follows a register write reaches it.
  logic [2*RE_W-1:0]    re_sq;
  logic [2*RE_W+J2_W-1:0] re_j2;
  logic [2*RE_W+J2_W+KS_W-1:0] k_full;
  logic [K_W-1:0]       k_val;

  j2g_mul #(.WA(RE_W), .WB(RE_W), .WS(1)) u_k1 (
    .clk, .rst, .vld(1'b1), .a(ref_radius), .b(ref_radius), .side(1'b0),
    .vld_o(), .p(re_sq), .side_o()
  );
  j2g_mul #(.WA(2*RE_W), .WB(J2_W), .WS(1)) u_k2 (
    .clk, .rst, .vld(1'b1), .a(re_sq), .b(j2_coefficient), .side(1'b0),
    .vld_o(), .p(re_j2), .side_o()
  );
  j2g_mul #(.WA(2*RE_W+J2_W), .WB(KS_W), .WS(1)) u_k3 (
    .clk, .rst, .vld(1'b1), .a(re_j2), .b(K_SCALE), .side(1'b0),
    .vld_o(), .p(k_full), .side_o()
  );
  assign k_val = k_full[K_W-1:0];

  // Input register: magnitudes and signs.
  logic    i_v;
  a_side_t i_sd;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_v <= 1'b0;
    end else begin
      i_v <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    i_sd.mag[0] <= mag_of(position.position_x);
    i_sd.mag[1] <= mag_of(position.position_y);
    i_sd.mag[2] <= mag_of(position.position_z);
    i_sd.neg    <= {position.position_z[POS_W-1], position.position_y[POS_W-1],
                    position.position_x[POS_W-1]};
  end

  // Squares of the three magnitudes.
  logic            a_v;
  a_side_t         a_sd;
  logic [SQ_W-1:0] sqx, sqy, sqz;

  j2g_mul #(.WA(MAG_W), .WB(MAG_W), .WS($bits(a_side_t))) u_sqx (
    .clk, .rst, .vld(i_v), .a(i_sd.mag[0]), .b(i_sd.mag[0]), .side(i_sd),
    .vld_o(a_v), .p(sqx), .side_o(a_sd)
  );
  j2g_mul #(.WA(MAG_W), .WB(MAG_W), .WS(1)) u_sqy (
    .clk, .rst, .vld(i_v), .a(i_sd.mag[1]), .b(i_sd.mag[1]), .side(1'b0),
    .vld_o(), .p(sqy), .side_o()
  );
  j2g_mul #(.WA(MAG_W), .WB(MAG_W), .WS(1)) u_sqz (
    .clk, .rst, .vld(i_v), .a(i_sd.mag[2]), .b(i_sd.mag[2]), .side(1'b0),
    .vld_o(), .p(sqz), .side_o()
  );

  // Radius squared and 5 z^2.
  logic            s_v;
  logic [R2_W-1:0] s_r2;
  logic [Z5_W-1:0] s_z5;
  a_side_t         s_sd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_v <= 1'b0;
    end else begin
      s_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    s_r2 <= R2_W'(sqx) + R2_W'(sqy) + R2_W'(sqz);
    s_z5 <= Z5_W'(sqz) + (Z5_W'(sqz) << 2);
    s_sd <= a_sd;
  end

  // Square root of r2 * 2^32, one result bit per stage, most significant first.
  logic [ROOT_W-1:0] rt_v;
  root_t             rt_st [ROOT_W];
  sq_side_t          rt_sd [ROOT_W];
  root_t             rt_in;

  assign rt_in = '{rem: {s_r2, {ROOT_SHIFT{1'b0}}}, root: '0};

  always_ff @(posedge clk) begin
    if (rst) begin
      rt_v <= '0;
    end else begin
      rt_v <= (rt_v << 1) | ROOT_W'(s_v);
    end
  end

  always_ff @(posedge clk) begin
    rt_st[0] <= root_step(rt_in, ROOT_W - 1);
    rt_sd[0] <= '{r2: s_r2, z5: s_z5, in: s_sd};
    for (int j = 1; j < ROOT_W; j++) begin
      rt_st[j] <= root_step(rt_st[j-1], ROOT_W - 1 - j);
      rt_sd[j] <= rt_sd[j-1];
    end
  end

  logic     rt_vo;
  sq_side_t rt_so;
  c_side_t  c_in;

  assign rt_vo = rt_v[ROOT_W-1];
  assign rt_so = rt_sd[ROOT_W-1];
  assign c_in  = '{root: rt_st[ROOT_W-1].root, r2: rt_so.r2, in: rt_so.in,
                   near: rt_so.r2 < R2_LIMIT};

  // r2^2, K r2 and 5 K z^2 in parallel.
  logic                    c_v;
  c_side_t                 c_sd;
  logic [R2_W+MB_WIDE-1:0] c_r2sq;
  logic [K_W+MB_WIDE-1:0]  c_kr, c_pz;

  j2g_mul #(.WA(R2_W), .WB(MB_WIDE), .WS($bits(c_side_t))) u_r2sq (
    .clk, .rst, .vld(rt_vo), .a(rt_so.r2), .b(MB_WIDE'(rt_so.r2)), .side(c_in),
    .vld_o(c_v), .p(c_r2sq), .side_o(c_sd)
  );
  j2g_mul #(.WA(K_W), .WB(MB_WIDE), .WS(1)) u_kr (
    .clk, .rst, .vld(rt_vo), .a(k_val), .b(MB_WIDE'(rt_so.r2)), .side(1'b0),
    .vld_o(), .p(c_kr), .side_o()
  );
  j2g_mul #(.WA(K_W), .WB(MB_WIDE), .WS(1)) u_pz (
    .clk, .rst, .vld(rt_vo), .a(k_val), .b(MB_WIDE'(rt_so.z5)), .side(1'b0),
    .vld_o(), .p(c_pz), .side_o()
  );

  // r2^3 and the scaled r2^2 term in parallel.
  logic                      d_v;
  d_side_t                   d_sd;
  d_side_t                   d_in;
  logic [R2SQ_W+MB_WIDE-1:0] d_r2c, d_cr;

  assign d_in = '{root: c_sd.root, kr: c_kr[KR_W-1:0], pz: c_pz[P_W-1:0], in: c_sd.in,
                  near: c_sd.near};

  j2g_mul #(.WA(R2SQ_W), .WB(MB_WIDE), .WS($bits(d_side_t))) u_r2c (
    .clk, .rst, .vld(c_v), .a(c_r2sq[R2SQ_W-1:0]), .b(MB_WIDE'(c_sd.r2)), .side(d_in),
    .vld_o(d_v), .p(d_r2c), .side_o(d_sd)
  );
  j2g_mul #(.WA(R2SQ_W), .WB(MB_WIDE), .WS(1)) u_cr (
    .clk, .rst, .vld(c_v), .a(c_r2sq[R2SQ_W-1:0]), .b(MB_WIDE'(C_MANT)), .side(1'b0),
    .vld_o(), .p(d_cr), .side_o()
  );

  // Subtrahends for x, y and for z.
  logic             e1_v;
  logic [R2C_W-1:0] e1_r2c;
  logic [ROOT_W-1:0] e1_root;
  logic [M_W-1:0]   e1_mxy, e1_mz, e1_pz;
  a_side_t          e1_in;
  logic             e1_near;
  logic [M_W-1:0]   kr_ext, cr_ext;

  assign kr_ext = M_W'(d_sd.kr);
  assign cr_ext = M_W'(d_cr[CR_W-1:0]) << C_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_v <= 1'b0;
    end else begin
      e1_v <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    e1_r2c   <= d_r2c[R2C_W-1:0];
    e1_root  <= d_sd.root;
    e1_mxy   <= kr_ext + cr_ext;
    e1_mz    <= kr_ext + (kr_ext << 1) + cr_ext;
    e1_pz    <= M_W'(d_sd.pz);
    e1_in    <= d_sd.in;
    e1_near  <= d_sd.near;
  end

  // Magnitude and sign of the bracket terms.
  logic              e2_v;
  logic [R2C_W-1:0]  e2_r2c;
  logic [ROOT_W-1:0] e2_root;
  logic [M_W-1:0]    e2_dxy, e2_dz;
  f_side_t           e2_sd;
  logic [M_W:0]      sub_xy, sub_z;

  assign sub_xy = {1'b0, e1_pz} - {1'b0, e1_mxy};
  assign sub_z  = {1'b0, e1_pz} - {1'b0, e1_mz};

  always_ff @(posedge clk) begin
    if (rst) begin
      e2_v <= 1'b0;
    end else begin
      e2_v <= e1_v;
    end
  end

  always_ff @(posedge clk) begin
    e2_r2c  <= e1_r2c;
    e2_root <= e1_root;
    e2_dxy  <= sub_xy[M_W] ? (e1_mxy - e1_pz) : sub_xy[M_W-1:0];
    e2_dz   <= sub_z[M_W] ? (e1_mz - e1_pz) : sub_z[M_W-1:0];
    e2_sd   <= '{in: e1_in, bneg_xy: sub_xy[M_W], bneg_z: sub_z[M_W], near: e1_near};
  end

  // Divisor r2^3 * root and the bracket terms times GM.
  logic                   f_v;
  f_side_t                f_sd;
  logic [DEN_W-1:0]       f_den;
  logic [M_W+MB_MID-1:0]  f_gxy, f_gz;

  j2g_mul #(.WA(R2C_W), .WB(ROOT_W), .WS($bits(f_side_t))) u_den (
    .clk, .rst, .vld(e2_v), .a(e2_r2c), .b(e2_root), .side(e2_sd),
    .vld_o(f_v), .p(f_den), .side_o(f_sd)
  );
  j2g_mul #(.WA(M_W), .WB(MB_MID), .WS(1)) u_gxy (
    .clk, .rst, .vld(e2_v), .a(e2_dxy), .b(MB_MID'(grav_param)), .side(1'b0),
    .vld_o(), .p(f_gxy), .side_o()
  );
  j2g_mul #(.WA(M_W), .WB(MB_MID), .WS(1)) u_gz (
    .clk, .rst, .vld(e2_v), .a(e2_dz), .b(MB_MID'(grav_param)), .side(1'b0),
    .vld_o(), .p(f_gz), .side_o()
  );

  // Numerators: times each coordinate magnitude.
  logic             g_v;
  g_side_t          g_sd;
  g_side_t          g_in;
  logic [NUM_W-1:0] g_nx, g_ny, g_nz;

  assign g_in = '{den: f_den, neg: f_sd.in.neg, bneg_xy: f_sd.bneg_xy, bneg_z: f_sd.bneg_z,
                  near: f_sd.near};

  j2g_mul #(.WA(G_W), .WB(MAG_W), .WS($bits(g_side_t))) u_nx (
    .clk, .rst, .vld(f_v), .a(f_gxy[G_W-1:0]), .b(f_sd.in.mag[0]), .side(g_in),
    .vld_o(g_v), .p(g_nx), .side_o(g_sd)
  );
  j2g_mul #(.WA(G_W), .WB(MAG_W), .WS(1)) u_ny (
    .clk, .rst, .vld(f_v), .a(f_gxy[G_W-1:0]), .b(f_sd.in.mag[1]), .side(1'b0),
    .vld_o(), .p(g_ny), .side_o()
  );
  j2g_mul #(.WA(G_W), .WB(MAG_W), .WS(1)) u_nz (
    .clk, .rst, .vld(f_v), .a(f_gz[G_W-1:0]), .b(f_sd.in.mag[2]), .side(1'b0),
    .vld_o(), .p(g_nz), .side_o()
  );

  // Three dividers share the divisor.
  logic             h_v;
  h_side_t          h_sd;
  h_side_t          h_in;
  logic [QUO_W-1:0] qx, qy, qz;
  logic             bx, by, bz;

  assign h_in = '{neg: g_sd.neg, bneg_xy: g_sd.bneg_xy, bneg_z: g_sd.bneg_z,
                  near: g_sd.near};

  j2g_div #(.WN(NUM_W), .WD(DEN_W), .WQ(QUO_W), .WS($bits(h_side_t))) u_divx (
    .clk, .rst, .vld(g_v), .num(g_nx), .den(g_sd.den), .side(h_in),
    .vld_o(h_v), .quot(qx), .big(bx), .side_o(h_sd)
  );
  j2g_div #(.WN(NUM_W), .WD(DEN_W), .WQ(QUO_W), .WS(1)) u_divy (
    .clk, .rst, .vld(g_v), .num(g_ny), .den(g_sd.den), .side(1'b0),
    .vld_o(), .quot(qy), .big(by), .side_o()
  );
  j2g_div #(.WN(NUM_W), .WD(DEN_W), .WQ(QUO_W), .WS(1)) u_divz (
    .clk, .rst, .vld(g_v), .num(g_nz), .den(g_sd.den), .side(1'b0),
    .vld_o(), .quot(qz), .big(bz), .side_o()
  );

  // Output register.
  logic [ACC_W:0] cx, cy, cz;

  assign cx = clip(qx, bx, h_sd.neg[0] != h_sd.bneg_xy);
  assign cy = clip(qy, by, h_sd.neg[1] != h_sd.bneg_xy);
  assign cz = clip(qz, bz, h_sd.neg[2] != h_sd.bneg_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= h_v;
    end
  end

  // Inside one metre the result is the zero vector with no clip flag.
  always_ff @(posedge clk) begin
    if (h_sd.near) begin
      accel <= '0;
    end else begin
      accel.accel_x   <= cx[ACC_W-1:0];
      accel.accel_y   <= cy[ACC_W-1:0];
      accel.accel_z   <= cz[ACC_W-1:0];
      accel.saturated <= cx[ACC_W] | cy[ACC_W] | cz[ACC_W];
    end
  end

endmodule

FILE: hw/rtl/j2g_mul.sv
// Pipelined shift-add multiplier, one operand digit per stage, with a sideband that travels along.
module j2g_mul
  import j2g_pkg::*;
#(
  parameter int WA = 8,
  parameter int WB = 8,
  parameter int WS = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             vld,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  input  logic [WS-1:0]    side,
  output logic             vld_o,
  output logic [WA+WB-1:0] p,
  output logic [WS-1:0]    side_o
);

  localparam int ND  = (WB + DIGIT_W - 1) / DIGIT_W;
  localparam int WBP = ND * DIGIT_W;
  localparam int WP  = WA + WB;

  logic [ND-1:0]  v;
  logic [WP-1:0]  acc [ND];
  logic [WA-1:0]  ar  [ND];
  logic [WBP-1:0] br  [ND];
  logic [WS-1:0]  sr  [ND];

  function automatic logic [WA+DIGIT_W-1:0] part(input logic [WA-1:0] x,
                                                 input logic [DIGIT_W-1:0] d);
    logic [WA+DIGIT_W-1:0] s;
    s = '0;
    for (int i = 0; i < DIGIT_W; i++) begin
      if (d[i]) s = s + ((WA + DIGIT_W)'(x) << i);
    end
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (v << 1) | ND'(vld);
    end
  end

  always_ff @(posedge clk) begin
    acc[0] <= WP'(part(a, b[DIGIT_W-1:0]));
    ar[0]  <= a;
    br[0]  <= WBP'(b);
    sr[0]  <= side;
    for (int k = 1; k < ND; k++) begin
      acc[k] <= acc[k-1] +
                (WP'(part(ar[k-1], br[k-1][k*DIGIT_W +: DIGIT_W])) << (k * DIGIT_W));
      ar[k]  <= ar[k-1];
      br[k]  <= br[k-1];
      sr[k]  <= sr[k-1];
    end
  end

  assign vld_o  = v[ND-1];
  assign p      = acc[ND-1];
  assign side_o = sr[ND-1];

endmodule

FILE: hw/rtl/j2g_div.sv
// Pipelined restoring divider, one quotient bit per stage, with an overflow flag.
module j2g_div #(
  parameter int WN = 16,
  parameter int WD = 8,
  parameter int WQ = 8,
  parameter int WS = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          vld,
  input  logic [WN-1:0] num,
  input  logic [WD-1:0] den,
  input  logic [WS-1:0] side,
  output logic          vld_o,
  output logic [WQ-1:0] quot,
  output logic          big,
  output logic [WS-1:0] side_o
);

  localparam int NS = WQ + 1;

  logic [NS-1:0] v;
  logic [WN-1:0] rem [NS];
  logic [WN-1:0] dr  [NS];
  logic [WQ-1:0] q   [NS];
  logic          bg  [NS];
  logic [WS-1:0] sr  [NS];
  logic [WN-1:0] den_ext;

  assign den_ext = WN'(den);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (v << 1) | NS'(vld);
    end
  end

  // The first stage only decides whether the quotient reaches 2^WQ.
  always_ff @(posedge clk) begin
    rem[0] <= num;
    dr[0]  <= den_ext;
    q[0]   <= '0;
    bg[0]  <= (num >> WQ) >= den_ext;
    sr[0]  <= side;
    for (int j = 1; j < NS; j++) begin
      if ((rem[j-1] >> (WQ - j)) >= dr[j-1]) begin
        rem[j] <= rem[j-1] - (dr[j-1] << (WQ - j));
        q[j]   <= q[j-1] | (WQ'(1) << (WQ - j));
      end else begin
        rem[j] <= rem[j-1];
        q[j]   <= q[j-1];
      end
      dr[j] <= dr[j-1];
      bg[j] <= bg[j-1];
      sr[j] <= sr[j-1];
    end
  end

  assign vld_o  = v[NS-1];
  assign quot   = q[NS-1];
  assign big    = bg[NS-1];
  assign side_o = sr[NS-1];

endmodule
